// ===== hdl/mptp_pkg.sv =====
// Package for the min-peak-utilization task placer.
// Word types, slot-load row type, status codes, controller states and the
// divider request/response structs. Used by mptp_div and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mptp_pkg;

  // fixed field widths
  localparam int SLOT_W    = 11;
  localparam int ID_W      = 16;
  localparam int FRAC_BITS = 16;
  localparam int LOAD_W    = FRAC_BITS + 1;
  localparam int QUO_W     = SLOT_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(QUO_W + 1);

  // processor lanes
  localparam int MAX_PROCS = 8;
  localparam int PIDX_W    = 3;
  localparam int NPROC_W   = 4;

  // one in Q1.FRAC_BITS
  localparam logic [LOAD_W-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

  // result status codes
  localparam logic [1:0] STAT_PLACED = 2'd0;
  localparam logic [1:0] STAT_DROP   = 2'd1;
  localparam logic [1:0] STAT_NOFIT  = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] now_slot;
    logic [SLOT_W-1:0] due_slot;
    logic [SLOT_W-1:0] work_slots;
    logic [ID_W-1:0]   task_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        chosen_processor;
    logic [SLOT_W-1:0] window_start;
    logic [SLOT_W-1:0] window_end;
    logic [LOAD_W-1:0] need_fraction;
    logic [ID_W-1:0]   echo_id;
  } out_word_t;

  // one memory row: the load of every processor at one slot
  typedef logic [MAX_PROCS-1:0][LOAD_W-1:0] row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_SCAN,
    ST_SELECT,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] dividend;
    logic [SLOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [LOAD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/mptp_div.sv =====
// Serial restoring divider: (dividend << FRAC_BITS) / divisor, one bit a cycle.
// Depends on mptp_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module mptp_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mptp_pkg::div_req_t req,
  output mptp_pkg::div_rsp_t      rsp
);
  import mptp_pkg::*;

  logic              busy_r, busy_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QUO_W-1:0]  dvd_r, dvd_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [SLOT_W-1:0] dsr_r, dsr_nxt;

  logic [SLOT_W:0]   trial;
  logic [SLOT_W:0]   diff;
  logic              ge;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, dvd_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(QUO_W);
      dvd_nxt  = {req.dividend, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[QUO_W-2:0], 1'b0};
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      rem_nxt = ge ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  // quotient does not exceed one in Q1.FRAC_BITS while dividend <= divisor
  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r[LOAD_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/min_peak_util_task_placer.sv =====
// Top level of the min-peak-utilization task placer: controller, slot-load
// memory and processor lanes. Depends on mptp_pkg and mptp_div.
//
//  channel | ports                        | direction | moves
//  --------+------------------------------+-----------+-----------------------
//  in      | in_valid, in_stall, in_word  | into      | one task word
//  out     | out_valid, out_stall, out_word| out of   | one placement word
//  cfg     | cfg_we, cfg_wdata            | into      | active processor count
//
// Flow: a dropped task goes from ST_IDLE straight to ST_OUT. For a placed task
// the slot-load memory port is swept once to check and once to add, and the
// divider produces one quotient bit per cycle; it is not started when work is
// zero. The start slot is reduced modulo TIME_SLOTS by repeated subtraction.
// Reset: a clearing pass writes TIME_SLOTS rows, one a cycle; in_stall is high
// until it ends. Stalls: one output register; the next task is taken while a
// result waits, and a finished result waits in ST_OUT for that register.
`timescale 1ns / 1ps
`default_nettype none

module min_peak_util_task_placer #(
  parameter int TIME_SLOTS = 2048
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire mptp_pkg::in_word_t  in_word,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      mptp_pkg::out_word_t out_word,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata
);
  import mptp_pkg::*;

  localparam int IDX_W = $clog2(TIME_SLOTS);

  // state and registers
  state_t            state_r, state_nxt;
  logic [3:0]        act_r;
  in_word_t          task_r, task_nxt;
  logic [SLOT_W:0]   red_r, red_nxt;
  logic [SLOT_W-1:0] len_r, len_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [IDX_W-1:0]  wa_r, wa_nxt;
  logic [LOAD_W-1:0] need_r, need_nxt;
  logic              rv_r, rv_nxt;
  row_t              rd_row_r;
  logic [MAX_PROCS-1:0] fit_r, fit_nxt;
  row_t              peak_r, peak_nxt;
  logic [NPROC_W-1:0] sel_r, sel_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [PIDX_W-1:0] best_r, best_nxt;
  logic [LOAD_W-1:0] bpeak_r, bpeak_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  // memory ports
  row_t              mem [TIME_SLOTS];
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_ra, mem_wa;
  row_t              mem_wd;

  // misc
  logic              in_acc;
  logic              infeas;
  logic [NPROC_W-1:0] nproc;
  logic              sweep_done;
  logic              red_big;
  logic              out_free;
  logic [PIDX_W-1:0] sel_p;
  logic [IDX_W-1:0]  idx_inc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // handshake and task checks
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign infeas = ({2'b00, in_word.work_slots} + {2'b00, in_word.now_slot} + 13'd1)
                  > {2'b00, in_word.due_slot};
  assign nproc  = (act_r > NPROC_W'(MAX_PROCS)) ? NPROC_W'(MAX_PROCS) : act_r;
  assign sweep_done = (cnt_r == '0) && !rv_r;
  assign red_big    = (32'(red_r) >= TIME_SLOTS);
  assign sel_p      = sel_r[PIDX_W-1:0];
  assign idx_inc    = (idx_r == IDX_W'(TIME_SLOTS - 1)) ? '0 : idx_r + IDX_W'(1);

  // divider launch on acceptance of a feasible task with nonzero work
  assign div_req.start    = in_acc && !infeas && (in_word.work_slots != '0);
  assign div_req.dividend = in_word.work_slots;
  assign div_req.divisor  = in_word.due_slot - in_word.now_slot - SLOT_W'(1);

  mptp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(TIME_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = infeas ? ST_OUT : ST_MOD;
      end
      ST_MOD: begin
        if (!red_big) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_rsp.busy) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sweep_done) state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        if (sel_r >= nproc) state_nxt = best_vld_r ? ST_WRITE : ST_OUT;
      end
      ST_WRITE: begin
        if (sweep_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    task_nxt     = task_r;
    red_nxt      = red_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    clr_nxt      = clr_r;
    wa_nxt       = wa_r;
    need_nxt     = need_r;
    rv_nxt       = 1'b0;
    fit_nxt      = fit_r;
    peak_nxt     = peak_r;
    sel_nxt      = sel_r;
    best_vld_nxt = best_vld_r;
    best_nxt     = best_r;
    bpeak_nxt    = bpeak_r;
    stat_nxt     = stat_r;
    out_nxt      = out_r;
    mem_re       = 1'b0;
    mem_ra       = idx_r;
    mem_we       = 1'b0;
    mem_wa       = wa_r;
    mem_wd       = rd_row_r;

    // result register drains independently of the controller
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + IDX_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          task_nxt = in_word;
          stat_nxt = STAT_DROP;
          red_nxt  = {1'b0, in_word.now_slot} + 12'd1;
          len_nxt  = in_word.due_slot - in_word.now_slot;
        end
      end
      ST_MOD: begin
        // start slot modulo the store depth
        if (red_big) red_nxt = red_r - (SLOT_W + 1)'(TIME_SLOTS);
      end
      ST_DIV: begin
        if (!div_rsp.busy) begin
          need_nxt = (task_r.work_slots == '0) ? '0 : div_rsp.quotient;
          idx_nxt  = IDX_W'(red_r);
          cnt_nxt  = len_r;
          fit_nxt  = '1;
          peak_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r != '0) begin
          mem_re  = 1'b1;
          rv_nxt  = 1'b1;
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r - SLOT_W'(1);
        end
        // each lane checks headroom and tracks its peak
        if (rv_r) begin
          for (int p = 0; p < MAX_PROCS; p++) begin
            if (({1'b0, rd_row_r[p]} + {1'b0, need_r}) >= {1'b0, ONE_FIX}) begin
              fit_nxt[p] = 1'b0;
            end else if (rd_row_r[p] > peak_r[p]) begin
              peak_nxt[p] = rd_row_r[p];
            end
          end
        end
        if (sweep_done) begin
          sel_nxt      = '0;
          best_vld_nxt = 1'b0;
        end
      end
      ST_SELECT: begin
        // one processor a cycle, lowest peak wins, ties to the lower index
        if (sel_r < nproc) begin
          if (fit_r[sel_p] && (!best_vld_r || (peak_r[sel_p] < bpeak_r))) begin
            best_vld_nxt = 1'b1;
            best_nxt     = sel_p;
            bpeak_nxt    = peak_r[sel_p];
          end
          sel_nxt = sel_r + NPROC_W'(1);
        end else begin
          stat_nxt = STAT_NOFIT;
          idx_nxt  = IDX_W'(red_r);
          cnt_nxt  = len_r;
        end
      end
      ST_WRITE: begin
        // read-modify-write, each write follows its read in the next cycle
        if (cnt_r != '0) begin
          mem_re  = 1'b1;
          rv_nxt  = 1'b1;
          wa_nxt  = idx_r;
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r - SLOT_W'(1);
        end
        if (rv_r) begin
          mem_we         = 1'b1;
          mem_wd[best_r] = rd_row_r[best_r] + need_r;
        end
        if (sweep_done) stat_nxt = STAT_PLACED;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_nxt.status           = stat_r;
          out_nxt.chosen_processor = (stat_r == STAT_PLACED) ? best_r : '0;
          out_nxt.window_start     = (stat_r == STAT_DROP) ? '0
                                     : task_r.now_slot + SLOT_W'(1);
          out_nxt.window_end       = (stat_r == STAT_DROP) ? '0 : task_r.due_slot;
          out_nxt.need_fraction    = (stat_r == STAT_DROP) ? '0 : need_r;
          out_nxt.echo_id          = task_r.task_id;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      act_r       <= 4'd8;
      clr_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) act_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    task_r     <= task_nxt;
    red_r      <= red_nxt;
    len_r      <= len_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    wa_r       <= wa_nxt;
    need_r     <= need_nxt;
    fit_r      <= fit_nxt;
    peak_r     <= peak_nxt;
    sel_r      <= sel_nxt;
    best_vld_r <= best_vld_nxt;
    best_r     <= best_nxt;
    bpeak_r    <= bpeak_nxt;
    stat_r     <= stat_nxt;
    out_r      <= out_nxt;
  end

  // slot-load memory, registered read
  always_ff @(posedge clk) begin
    if (mem_re) rd_row_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // assertions
  a_no_rmw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("slot-load read and write hit the same row");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_need_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (need_r <= ONE_FIX))
    else $error("need exceeds one");

  a_write_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> best_vld_r)
    else $error("write-back without a chosen processor");

  a_placed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free && stat_r == STAT_PLACED)
      |=> (out_valid_r && ({1'b0, out_r.chosen_processor} < nproc)))
    else $error("placed on an inactive processor");

endmodule

`default_nettype wire
